### src/liang_barsky_line_clip_core_macros.svh
// assertion macros for the line clip core checker
`ifndef LIANG_BARSKY_LINE_CLIP_CORE_MACROS_SVH
`define LIANG_BARSKY_LINE_CLIP_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define LBC_ASSERT_IMPLY(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication, off during reset
`define LBC_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

// next-cycle implication, always on
`define LBC_ASSERT_NEXT_ALWAYS(label, clk, a, c, msg) \
  label: assert property (@(posedge clk) (a) |=> (c)) else $error(msg);

`endif

### src/lbc_pkg.sv
// shared constants and types of the line clip core
`timescale 1ns / 1ps
package lbc_pkg;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int APB_ADDR_W      = 4;
  localparam int APB_DATA_W      = 32;
  localparam int WIN_LEFT_RST    = -40;
  localparam int WIN_BOTTOM_RST  = 40;
  localparam int WIN_RIGHT_RST   = 100;
  localparam int WIN_TOP_RST     = 150;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_BOTTOM = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_TOP    = 2'd3
  } reg_idx_t;
endpackage

### src/lbc_if.sv
// segment request and clip result channel interfaces
`timescale 1ns / 1ps
interface lbc_in_if #(parameter int CW = 16) ();
  logic valid;
  logic ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lbc_out_if #(parameter int CW = 16) ();
  logic valid;
  logic ready;
  logic visible;
  logic signed [CW-1:0] clip_start_x;
  logic signed [CW-1:0] clip_start_y;
  logic signed [CW-1:0] clip_end_x;
  logic signed [CW-1:0] clip_end_y;
  modport source (output valid, visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y,
                  input ready);
  modport sink (input valid, visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y,
                output ready);
endinterface

### src/lbc_front.sv
// front end: edge deltas, boundary distances and parallel-edge rejection
`timescale 1ns / 1ps
module lbc_front #(
  parameter int CW = lbc_pkg::COORD_WIDTH_DEF
) (
  input  logic signed [CW-1:0] x0,
  input  logic signed [CW-1:0] y0,
  input  logic signed [CW-1:0] x1,
  input  logic signed [CW-1:0] y1,
  input  logic signed [CW-1:0] win_left,
  input  logic signed [CW-1:0] win_bottom,
  input  logic signed [CW-1:0] win_right,
  input  logic signed [CW-1:0] win_top,
  output logic [1+2*CW+6*(CW+1)-1:0] entry
);
  localparam int DW = CW + 1;

  logic signed [DW-1:0] dx, dy, q0, q1, q2, q3;
  logic par_rej;

  assign dx = DW'(x1) - DW'(x0);
  assign dy = DW'(y1) - DW'(y0);
  assign q0 = DW'(x0) - DW'(win_left);
  assign q1 = DW'(win_right) - DW'(x0);
  assign q2 = DW'(y0) - DW'(win_bottom);
  assign q3 = DW'(win_top) - DW'(y0);

  // parallel edge lying outside its boundary
  assign par_rej = ((dx == '0) && (q0 < 0 || q1 < 0)) ||
                   ((dy == '0) && (q2 < 0 || q3 < 0));

  assign entry = {par_rej, x0, y0, dx, dy, q3, q2, q1, q0};
endmodule

### src/lbc_fifo.sv
// short queue between front and back
`timescale 1ns / 1ps
module lbc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = lbc_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         nonempty
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  ent [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full     = (count == (AW+1)'(DEPTH));
  assign nonempty = (count != '0);
  assign dout     = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

### src/lbc_div.sv
// pipelined restoring divider, one quotient bit per stage, saturated at two
`timescale 1ns / 1ps
module lbc_div #(
  parameter int DW   = 17,
  parameter int FRAC = lbc_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] p,
  input  logic signed [DW-1:0] q,
  output logic signed [FRAC+2:0] r
);
  localparam int NW = DW + FRAC + 1;
  localparam int NS = FRAC + 2;

  logic [NW-1:0]   rem [NS];
  logic [FRAC:0]   quo [NS];
  logic [DW-1:0]   mp  [NS];
  logic            neg [NS];
  logic            sat [NS];
  logic [DW-1:0]   mq_in, mp_in;
  logic [FRAC+1:0] mag;

  assign mq_in = (q < 0) ? DW'(-q) : DW'(q);
  assign mp_in = (p < 0) ? DW'(-p) : DW'(p);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= NW'(mq_in) << FRAC;
      quo[0] <= '0;
      mp[0]  <= mp_in;
      neg[0] <= (q < 0) ^ (p < 0);
      sat[0] <= {1'b0, mq_in} >= {mp_in, 1'b0};
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_step
    localparam int K = FRAC + 1 - s;
    logic [NW-1:0] dsh;
    logic          take;
    assign dsh  = NW'(mp[s-1]) << K;
    assign take = rem[s-1] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= take ? rem[s-1] - dsh : rem[s-1];
        quo[s] <= {quo[s-1][FRAC-1:0], take};
        mp[s]  <= mp[s-1];
        neg[s] <= neg[s-1];
        sat[s] <= sat[s-1];
      end
    end
  end

  assign mag = sat[NS-1] ? {1'b1, {(FRAC+1){1'b0}}} : {1'b0, quo[NS-1]};
  assign r   = neg[NS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
endmodule

### src/lbc_back.sv
// back end: four divider lanes, boundary tests, endpoint interpolation
`timescale 1ns / 1ps
module lbc_back #(
  parameter int CW   = lbc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC = lbc_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [1+2*CW+6*(CW+1)-1:0] head,
  input  logic                       head_valid,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       visible,
  output logic signed [CW-1:0]       clip_start_x,
  output logic signed [CW-1:0]       clip_start_y,
  output logic signed [CW-1:0]       clip_end_x,
  output logic signed [CW-1:0]       clip_end_y
);
  localparam int DW = CW + 1;
  localparam int L  = FRAC + 2;
  localparam int UW = FRAC + 3;
  localparam int PW = FRAC + 2 + DW;
  localparam logic signed [UW-1:0] U_ONE = {2'b00, 1'b1, {FRAC{1'b0}}};
  localparam logic signed [PW-1:0] HALF  = PW'(1) << (FRAC - 1);

  logic                 h_rej;
  logic signed [CW-1:0] h_x0, h_y0;
  logic signed [DW-1:0] h_dx, h_dy, h_q3, h_q2, h_q1, h_q0;
  logic signed [DW-1:0] lane_p [4];
  logic signed [DW-1:0] lane_q [4];
  logic signed [UW-1:0] lane_r [4];
  logic                 en;

  assign {h_rej, h_x0, h_y0, h_dx, h_dy, h_q3, h_q2, h_q1, h_q0} = head;
  assign en  = !out_valid || out_ready;
  assign pop = en && head_valid;

  assign lane_p[0] = -h_dx;
  assign lane_p[1] = h_dx;
  assign lane_p[2] = -h_dy;
  assign lane_p[3] = h_dy;
  assign lane_q[0] = h_q0;
  assign lane_q[1] = h_q1;
  assign lane_q[2] = h_q2;
  assign lane_q[3] = h_q3;

  for (genvar e = 0; e < 4; e++) begin : g_lane
    lbc_div #(.DW(DW), .FRAC(FRAC)) u_div (
      .clk (clk),
      .en  (en),
      .p   (lane_p[e]),
      .q   (lane_q[e]),
      .r   (lane_r[e])
    );
  end

  // side data alongside the divider stages
  logic                 vld [L];
  logic                 srej [L];
  logic signed [CW-1:0] sx0 [L];
  logic signed [CW-1:0] sy0 [L];
  logic signed [DW-1:0] sdx [L];
  logic signed [DW-1:0] sdy [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < L; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[0] <= head_valid;
      for (int s = 1; s < L; s++) vld[s] <= vld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      srej[0] <= h_rej;
      sx0[0]  <= h_x0;
      sy0[0]  <= h_y0;
      sdx[0]  <= h_dx;
      sdy[0]  <= h_dy;
      for (int s = 1; s < L; s++) begin
        srej[s] <= srej[s-1];
        sx0[s]  <= sx0[s-1];
        sy0[s]  <= sy0[s-1];
        sdx[s]  <= sdx[s-1];
        sdy[s]  <= sdy[s-1];
      end
    end
  end

  // boundary tests in left, right, bottom, top order
  logic [3:0]           pz, pneg;
  logic signed [UW-1:0] u1, u2;
  logic                 ok;

  assign pz   = {sdy[L-1] == '0, sdy[L-1] == '0, sdx[L-1] == '0, sdx[L-1] == '0};
  assign pneg = {sdy[L-1] < 0, sdy[L-1] > 0, sdx[L-1] < 0, sdx[L-1] > 0};

  always_comb begin
    u1 = '0;
    u2 = U_ONE;
    ok = !srej[L-1];
    for (int e = 0; e < 4; e++) begin
      if (!pz[e]) begin
        if (pneg[e]) begin
          if (lane_r[e] > u2) ok = 1'b0;
          else if (lane_r[e] > u1) u1 = lane_r[e];
        end else begin
          if (lane_r[e] < u1) ok = 1'b0;
          else if (lane_r[e] < u2) u2 = lane_r[e];
        end
      end
    end
  end

  logic                 t_vld, t_ok;
  logic [FRAC:0]        t_u1, t_u2;
  logic signed [CW-1:0] t_x0, t_y0;
  logic signed [DW-1:0] t_dx, t_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld <= 1'b0;
    end else if (en) begin
      t_vld <= vld[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_ok <= ok;
      t_u1 <= u1[FRAC:0];
      t_u2 <= u2[FRAC:0];
      t_x0 <= sx0[L-1];
      t_y0 <= sy0[L-1];
      t_dx <= sdx[L-1];
      t_dy <= sdy[L-1];
    end
  end

  // u times delta
  logic                 m_vld, m_ok, m_end, m_start;
  logic signed [CW-1:0] m_x0, m_y0;
  logic signed [DW-1:0] m_dx, m_dy;
  logic signed [PW-1:0] m_ex, m_ey, m_sx, m_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (en) begin
      m_vld <= t_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_ok    <= t_ok;
      m_end   <= t_u2 != U_ONE[FRAC:0];
      m_start <= t_u1 != '0;
      m_x0    <= t_x0;
      m_y0    <= t_y0;
      m_dx    <= t_dx;
      m_dy    <= t_dy;
      m_ex    <= $signed({1'b0, t_u2}) * t_dx;
      m_ey    <= $signed({1'b0, t_u2}) * t_dy;
      m_sx    <= $signed({1'b0, t_u1}) * t_dx;
      m_sy    <= $signed({1'b0, t_u1}) * t_dy;
    end
  end

  // round half up and offset from the start point
  logic signed [PW-1:0] f_ex, f_ey, f_sx, f_sy;
  logic signed [CW-1:0] n_ex, n_ey, n_sx, n_sy;

  assign f_ex = (m_ex + HALF) >>> FRAC;
  assign f_ey = (m_ey + HALF) >>> FRAC;
  assign f_sx = (m_sx + HALF) >>> FRAC;
  assign f_sy = (m_sy + HALF) >>> FRAC;

  assign n_ex = m_end ? CW'(PW'(m_x0) + f_ex) : CW'(DW'(m_x0) + m_dx);
  assign n_ey = m_end ? CW'(PW'(m_y0) + f_ey) : CW'(DW'(m_y0) + m_dy);
  assign n_sx = m_start ? CW'(PW'(m_x0) + f_sx) : m_x0;
  assign n_sy = m_start ? CW'(PW'(m_y0) + f_sy) : m_y0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      visible      <= m_ok;
      clip_start_x <= m_ok ? n_sx : '0;
      clip_start_y <= m_ok ? n_sy : '0;
      clip_end_x   <= m_ok ? n_ex : '0;
      clip_end_y   <= m_ok ? n_ey : '0;
    end
  end
endmodule

### src/liang_barsky_line_clip_core.sv
// Liang-Barsky line clipper: takes one segment per cycle while the queue is not
// full and returns one result per segment, in order. A segment is classified on
// entry and queued; the back end runs four restoring dividers that give one
// quotient bit per stage, then registers the boundary tests, the products and
// the result. The queue holds four segments, so the input keeps accepting until
// the queue fills while the output waits.
// The window registers sit at APB byte addresses 0, 4, 8 and 12 (left, bottom,
// right, top); write them only while no segment is in flight.
`timescale 1ns / 1ps
module liang_barsky_line_clip_core #(
  parameter int COORD_WIDTH = lbc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = lbc_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  lbc_in_if.sink                          seg_in,
  lbc_out_if.source                       seg_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lbc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lbc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lbc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import lbc_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int EW = 1 + 2*CW + 6*(CW+1);

  logic signed [CW-1:0] win_left, win_bottom, win_right, win_top;
  logic                 wr_en;
  reg_idx_t             idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= CW'(WIN_LEFT_RST);
      win_bottom <= CW'(WIN_BOTTOM_RST);
      win_right  <= CW'(WIN_RIGHT_RST);
      win_top    <= CW'(WIN_TOP_RST);
    end else if (wr_en) begin
      case (idx)
        REG_LEFT:   win_left   <= pwdata[CW-1:0];
        REG_BOTTOM: win_bottom <= pwdata[CW-1:0];
        REG_RIGHT:  win_right  <= pwdata[CW-1:0];
        REG_TOP:    win_top    <= pwdata[CW-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LEFT:   prdata = APB_DATA_W'(win_left);
      REG_BOTTOM: prdata = APB_DATA_W'(win_bottom);
      REG_RIGHT:  prdata = APB_DATA_W'(win_right);
      REG_TOP:    prdata = APB_DATA_W'(win_top);
      default:    prdata = '0;
    endcase
  end

  logic [EW-1:0] entry, head;
  logic          full, head_valid, pop, push;

  assign push         = seg_in.valid && !full;
  assign seg_in.ready = !full;

  lbc_front #(.CW(CW)) u_front (
    .x0         (seg_in.start_x),
    .y0         (seg_in.start_y),
    .x1         (seg_in.end_x),
    .y1         (seg_in.end_y),
    .win_left   (win_left),
    .win_bottom (win_bottom),
    .win_right  (win_right),
    .win_top    (win_top),
    .entry      (entry)
  );

  lbc_fifo #(.W(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (entry),
    .full     (full),
    .pop      (pop),
    .dout     (head),
    .nonempty (head_valid)
  );

  lbc_back #(.CW(CW), .FRAC(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .out_valid    (seg_out.valid),
    .out_ready    (seg_out.ready),
    .visible      (seg_out.visible),
    .clip_start_x (seg_out.clip_start_x),
    .clip_start_y (seg_out.clip_start_y),
    .clip_end_x   (seg_out.clip_end_x),
    .clip_end_y   (seg_out.clip_end_y)
  );
endmodule

### src/lbc_checker.sv
// port-level checker for the line clip core and its bind
`timescale 1ns / 1ps
`include "liang_barsky_line_clip_core_macros.svh"
module lbc_checker #(
  parameter int CW = lbc_pkg::COORD_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input logic          out_visible,
  input logic [CW-1:0] out_sx,
  input logic [CW-1:0] out_sy,
  input logic [CW-1:0] out_ex,
  input logic [CW-1:0] out_ey,
  input logic          pready
);
  `LBC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `LBC_ASSERT_IMPLY(a_reject_zero, clk, rst, out_valid && !out_visible, (out_sx == '0) && (out_sy == '0) && (out_ex == '0) && (out_ey == '0), "rejected segment with nonzero coordinates")
  `LBC_ASSERT_NEXT_ALWAYS(a_rst_idle, clk, rst, !out_valid, "result valid right after reset")
  `LBC_ASSERT_IMPLY(a_pready, clk, rst, 1'b1, pready, "config port not ready")
endmodule

bind liang_barsky_line_clip_core lbc_checker #(.CW(COORD_WIDTH)) u_lbc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (seg_out.valid),
  .out_ready   (seg_out.ready),
  .out_visible (seg_out.visible),
  .out_sx      (seg_out.clip_start_x),
  .out_sy      (seg_out.clip_start_y),
  .out_ex      (seg_out.clip_end_x),
  .out_ey      (seg_out.clip_end_y),
  .pready      (pready)
);
